### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/pprj_pkg.sv
// ---------------------------------------------------------------------------
// pprj_pkg
// Shared types, register indexes and fixed-point helpers for the
// point-to-plane residual and jacobian core
// ---------------------------------------------------------------------------
`default_nettype none

package pprj_pkg;

   // csr map
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned FIX_W     = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_X = 3'd0,
      CSR_TRANS_Y = 3'd1,
      CSR_TRANS_Z = 3'd2,
      CSR_QUAT_X  = 3'd3,
      CSR_QUAT_Y  = 3'd4,
      CSR_QUAT_Z  = 3'd5,
      CSR_QUAT_W  = 3'd6
   } csr_index_type;

   // number types
   typedef logic signed [FIX_W-1:0] fix_type;    // Q16.16 or Q2.30
   typedef logic signed [63:0]      prod_type;   // full product
   typedef logic signed [33:0]      rnd_type;    // product rounded by 2^30
   typedef logic signed [36:0]      acc_type;    // sum before saturation
   typedef fix_type [2:0]           vec3_type;
   typedef vec3_type [2:0]          mat3_type;   // [row][col]

   localparam fix_type QUAT_W_RESET = 32'sh4000_0000;
   localparam acc_type ONE_Q30      = acc_type'(32'sh4000_0000);
   localparam acc_type ACC_MAX      = acc_type'(32'sh7fff_ffff);
   localparam acc_type ACC_MIN      = acc_type'(32'sh8000_0000);
   localparam prod_type RND_HALF    = prod_type'(64'sh2000_0000);

   // clock cycles for the rotation matrix to follow a csr write
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
      fix_type w;
   } quat_type;

   typedef struct packed {
      fix_type normal_x;
      fix_type normal_y;
      fix_type normal_z;
      fix_type plane_offset;
      fix_type point_x;
      fix_type point_y;
      fix_type point_z;
   } req_payload_type;

   typedef struct packed {
      fix_type residual;
      fix_type jac_trans_x;
      fix_type jac_trans_y;
      fix_type jac_trans_z;
      fix_type jac_rot_x;
      fix_type jac_rot_y;
      fix_type jac_rot_z;
   } rsp_payload_type;

   // exact signed 32x32 product
   function automatic prod_type mul_full(input fix_type a, input fix_type b);
      prod_type pa;
      prod_type pb;
      pa = prod_type'(a);
      pb = prod_type'(b);
      return pa * pb;
   endfunction

   // round half up, scale down by 2^30
   function automatic rnd_type rnd30(input prod_type p);
      prod_type t;
      t = p + RND_HALF;
      return rnd_type'(t[63:30]);
   endfunction

   function automatic acc_type ext(input rnd_type r);
      return acc_type'(r);
   endfunction

   // clamp to the 32-bit signed range
   function automatic fix_type sat32(input acc_type v);
      fix_type r;
      if (v > ACC_MAX) begin
         r = ACC_MAX[31:0];
      end else if (v < ACC_MIN) begin
         r = ACC_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/point_plane_residual_jacobian_core.sv
// ---------------------------------------------------------------------------
// point_plane_residual_jacobian_core
// Point-to-plane residual and six-entry pose jacobian for a laser point
// ---------------------------------------------------------------------------
// Takes one point/plane beat per clock while req_stall is low and returns one
// result beat per request through four register stages (products with the
// rotation matrix, rounded sums, second products, final sums into the
// output register). A stalled output register holds the whole pipeline.
// The rotation matrix is rebuilt from the quaternion registers by a
// two-stage unit; after reset and after every csr write req_stall stays high
// while that matrix refreshes. Write csrs only while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module point_plane_residual_jacobian_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire pprj_pkg::req_payload_type         req_payload,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output pprj_pkg::rsp_payload_type              rsp_payload,
   // csr write port
   input  wire logic                              csr_write,
   input  wire logic [pprj_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire pprj_pkg::fix_type                 csr_wdata
);
   import pprj_pkg::*;

   // csr registers
   vec3_type  trans_ff;
   quat_type  quat_ff;
   logic [1:0] settle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff  <= '0;
         quat_ff   <= '{x: '0, y: '0, z: '0, w: QUAT_W_RESET};
         settle_ff <= SETTLE_CYCLES;
      end else if (csr_write) begin
         settle_ff <= SETTLE_CYCLES;
         unique case (csr_index)
            CSR_TRANS_X: trans_ff[0] <= csr_wdata;
            CSR_TRANS_Y: trans_ff[1] <= csr_wdata;
            CSR_TRANS_Z: trans_ff[2] <= csr_wdata;
            CSR_QUAT_X:  quat_ff.x   <= csr_wdata;
            CSR_QUAT_Y:  quat_ff.y   <= csr_wdata;
            CSR_QUAT_Z:  quat_ff.z   <= csr_wdata;
            CSR_QUAT_W:  quat_ff.w   <= csr_wdata;
            default: ;
         endcase
      end else if (settle_ff != 2'd0) begin
         settle_ff <= settle_ff - 2'd1;
      end
   end

   // rotation matrix
   mat3_type rot;

   pprj_rot u_rot (
      .clock (clock),
      .quat  (quat_ff),
      .rot   (rot)
   );

   // pipeline flow control
   logic en;
   logic req_accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en         = !v4_ff || !rsp_stall;
   assign req_stall  = !en || (settle_ff != 2'd0);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: R*p and n^T*R products
   vec3_type        pnt, nrm;
   prod_type        rp_ff [3][3];
   prod_type        nr_ff [3][3];
   req_payload_type s1_ff;

   assign pnt = {req_payload.point_z, req_payload.point_y, req_payload.point_x};
   assign nrm = {req_payload.normal_z, req_payload.normal_y, req_payload.normal_x};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= req_payload;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               rp_ff[i][j] <= mul_full(rot[i][j], pnt[j]);
               nr_ff[i][j] <= mul_full(nrm[i], rot[i][j]);
            end
         end
      end
   end

   // stage 2: transformed point and m = R^T n
   vec3_type        pt_in, m_in;
   vec3_type        pt_ff, m_ff;
   req_payload_type s2_ff;

   always_comb begin
      acc_type acc_p, acc_m;
      for (int i = 0; i < 3; i++) begin
         acc_p = acc_type'(trans_ff[i]) + ext(rnd30(rp_ff[i][0]))
               + ext(rnd30(rp_ff[i][1])) + ext(rnd30(rp_ff[i][2]));
         acc_m = ext(rnd30(nr_ff[0][i])) + ext(rnd30(nr_ff[1][i]))
               + ext(rnd30(nr_ff[2][i]));
         pt_in[i] = sat32(acc_p);
         m_in[i]  = sat32(acc_m);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s1_ff;
         pt_ff <= pt_in;
         m_ff  <= m_in;
      end
   end

   // stage 3: n.pt products and cross product terms of p x m
   vec3_type        p2, n2;
   prod_type        npt_ff [3];
   prod_type        cra_ff [3];
   prod_type        crb_ff [3];
   req_payload_type s3_ff;

   assign p2 = {s2_ff.point_z, s2_ff.point_y, s2_ff.point_x};
   assign n2 = {s2_ff.normal_z, s2_ff.normal_y, s2_ff.normal_x};

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s2_ff;
         for (int i = 0; i < 3; i++) begin
            npt_ff[i] <= mul_full(n2[i], pt_ff[i]);
         end
         cra_ff[0] <= mul_full(p2[1], m_ff[2]);
         crb_ff[0] <= mul_full(p2[2], m_ff[1]);
         cra_ff[1] <= mul_full(p2[2], m_ff[0]);
         crb_ff[1] <= mul_full(p2[0], m_ff[2]);
         cra_ff[2] <= mul_full(p2[0], m_ff[1]);
         crb_ff[2] <= mul_full(p2[1], m_ff[0]);
      end
   end

   // stage 4: residual, rotation jacobian, output register
   rsp_payload_type rsp_in;
   rsp_payload_type rsp_ff;

   always_comb begin
      acc_type acc_r;
      acc_type jr0, jr1, jr2;
      acc_r = acc_type'(s3_ff.plane_offset) + ext(rnd30(npt_ff[0]))
            + ext(rnd30(npt_ff[1])) + ext(rnd30(npt_ff[2]));
      jr0   = ext(rnd30(cra_ff[0])) - ext(rnd30(crb_ff[0]));
      jr1   = ext(rnd30(cra_ff[1])) - ext(rnd30(crb_ff[1]));
      jr2   = ext(rnd30(cra_ff[2])) - ext(rnd30(crb_ff[2]));
      rsp_in.residual    = sat32(acc_r);
      rsp_in.jac_trans_x = s3_ff.normal_x;
      rsp_in.jac_trans_y = s3_ff.normal_y;
      rsp_in.jac_trans_z = s3_ff.normal_z;
      rsp_in.jac_rot_x   = sat32(jr0);
      rsp_in.jac_rot_y   = sat32(jr1);
      rsp_in.jac_rot_z   = sat32(jr2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = v4_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `ASSERT_IMPLIES(a_settle_blocks_req, clock, reset, settle_ff != 2'd0, req_stall)
   `ASSERT_NEXT(a_csr_write_blocks_req, clock, reset, csr_write, req_stall)
   `ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_accept, v1_ff)
   `ASSERT_NEXT(a_stall_freezes_pipe, clock, reset, v4_ff && rsp_stall, $stable(v3_ff))

endmodule

`default_nettype wire

### hdl/pprj_rot.sv
// ---------------------------------------------------------------------------
// pprj_rot
// Two-stage rotation matrix from the configured quaternion: products of
// quaternion components, then rounding, combination and saturation
// ---------------------------------------------------------------------------
`default_nettype none

module pprj_rot (
   input  wire logic               clock,
   input  wire pprj_pkg::quat_type quat,
   output pprj_pkg::mat3_type      rot
);
   import pprj_pkg::*;

   prod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   mat3_type rot_ff;
   mat3_type rot_in;

   // quaternion component products
   always_ff @(posedge clock) begin
      xx_ff <= mul_full(quat.x, quat.x);
      yy_ff <= mul_full(quat.y, quat.y);
      zz_ff <= mul_full(quat.z, quat.z);
      xy_ff <= mul_full(quat.x, quat.y);
      xz_ff <= mul_full(quat.x, quat.z);
      yz_ff <= mul_full(quat.y, quat.z);
      wx_ff <= mul_full(quat.w, quat.x);
      wy_ff <= mul_full(quat.w, quat.y);
      wz_ff <= mul_full(quat.w, quat.z);
   end

   // usual unit-quaternion matrix, Q2.30
   always_comb begin
      acc_type xx, yy, zz, xy, xz, yz, wx, wy, wz;
      xx = ext(rnd30(xx_ff));
      yy = ext(rnd30(yy_ff));
      zz = ext(rnd30(zz_ff));
      xy = ext(rnd30(xy_ff));
      xz = ext(rnd30(xz_ff));
      yz = ext(rnd30(yz_ff));
      wx = ext(rnd30(wx_ff));
      wy = ext(rnd30(wy_ff));
      wz = ext(rnd30(wz_ff));
      rot_in[0][0] = sat32(ONE_Q30 - ((yy + zz) <<< 1));
      rot_in[0][1] = sat32((xy - wz) <<< 1);
      rot_in[0][2] = sat32((xz + wy) <<< 1);
      rot_in[1][0] = sat32((xy + wz) <<< 1);
      rot_in[1][1] = sat32(ONE_Q30 - ((xx + zz) <<< 1));
      rot_in[1][2] = sat32((yz - wx) <<< 1);
      rot_in[2][0] = sat32((xz - wy) <<< 1);
      rot_in[2][1] = sat32((yz + wx) <<< 1);
      rot_in[2][2] = sat32(ONE_Q30 - ((xx + yy) <<< 1));
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire
